@@ sv/btci_pkg.sv @@
`timescale 1ns / 1ps
package btci_pkg;

	localparam int NUM_LANES = 4;
	localparam int SAMPLE_W  = 12;
	localparam int WINDOW_W  = 8;
	localparam int THRESH_W  = 12;
	localparam int PROD_W    = SAMPLE_W + WINDOW_W;
	localparam int BASE_W    = 20;
	localparam int CHARGE_W  = 30;
	localparam int INDEX_W   = 11;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 2;

	localparam logic [CHARGE_W-1:0] CHARGE_MAX   = CHARGE_W'(1069286400);
	localparam logic [INDEX_W-1:0]  INDEX_MAX    = INDEX_W'(2047);
	localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(30);
	localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(20);

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [CHARGE_W-1:0] charge_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW = 2'd0,
		REG_THRESH = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic                load;
		logic                fire;
		logic [WINDOW_W-1:0] window;
		logic                in_window_s1;
		logic                last_s1;
		logic [PROD_W-1:0]   limit_s1;
	} ctrl_t;

endpackage

@@ sv/btci_lane.sv @@
`timescale 1ns / 1ps
module btci_lane import btci_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  ctrl_t   ctrl,
	input  sample_t sample,
	output charge_t charge_next
);

	sample_t             sample_s1;
	logic [PROD_W-1:0]   prod_s1;
	logic [BASE_W-1:0]   bsum_q;
	charge_t             charge_q;
	logic [PROD_W:0]     excess;
	logic                scored;
	logic [CHARGE_W:0]   sum;
	charge_t             sat;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			sample_s1 <= sample;
			prod_s1   <= PROD_W'(sample) * PROD_W'(ctrl.window);
		end
	end

	// excess scaled by window: s*W - baseline_sum, signed
	always_comb begin
		excess = {1'b0, prod_s1} - {1'b0, PROD_W'(bsum_q)};
		scored = !excess[PROD_W] && (excess[PROD_W-1:0] > ctrl.limit_s1);
		sum    = {1'b0, charge_q} + (CHARGE_W+1)'(excess[PROD_W-1:0]);
		sat    = (sum > {1'b0, CHARGE_MAX}) ? CHARGE_MAX : sum[CHARGE_W-1:0];
		if (!ctrl.in_window_s1 && scored) begin
			charge_next = sat;
		end else begin
			charge_next = charge_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsum_q   <= '0;
			charge_q <= '0;
		end else if (ctrl.fire) begin
			if (ctrl.last_s1) begin
				bsum_q   <= '0;
				charge_q <= '0;
			end else if (ctrl.in_window_s1) begin
				bsum_q <= bsum_q + BASE_W'(sample_s1);
			end else begin
				charge_q <= charge_next;
			end
		end
	end

endmodule

@@ sv/btci_ctrl.sv @@
`timescale 1ns / 1ps
module btci_ctrl import btci_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  logic                 last_sample,
	input  logic                 out_busy,
	output ctrl_t                ctrl
);

	logic [WINDOW_W-1:0] window_q;
	logic [THRESH_W-1:0] thresh_q;
	logic [INDEX_W-1:0]  idx_q;
	logic                valid_s1;
	logic                in_window_s1;
	logic                last_s1;
	logic [PROD_W-1:0]   limit_s1;
	logic                load;
	logic                fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
			thresh_q <= THRESH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW: window_q <= cfg_data[WINDOW_W-1:0];
				REG_THRESH: thresh_q <= cfg_data[THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	// a last beat in stage 1 waits only while the result register is held
	assign fire         = valid_s1 && !(last_s1 && out_busy);
	assign sample_stall = valid_s1 && !fire;
	assign load         = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
				if (last_sample) begin
					idx_q <= '0;
				end else if (idx_q != INDEX_MAX) begin
					idx_q <= idx_q + 1'b1;
				end
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			in_window_s1 <= idx_q < INDEX_W'(window_q);
			last_s1      <= last_sample;
			limit_s1     <= PROD_W'(thresh_q) * PROD_W'(window_q);
		end
	end

	always_comb begin
		ctrl.load         = load;
		ctrl.fire         = fire;
		ctrl.window       = window_q;
		ctrl.in_window_s1 = in_window_s1;
		ctrl.last_s1      = last_s1;
		ctrl.limit_s1     = limit_s1;
	end

endmodule

@@ sv/btci_merge.sv @@
`timescale 1ns / 1ps
module btci_merge import btci_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire_last,
	input  charge_t [NUM_LANES-1:0]       charge_next,
	input  logic                          result_stall,
	output logic                          result_valid,
	output charge_t [NUM_LANES-1:0]       charge_q,
	output logic [NUM_LANES-1:0]          hit_mask
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (fire_last) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_last) begin
			charge_q <= charge_next;
			for (int i = 0; i < NUM_LANES; i++) begin
				hit_mask[i] <= charge_next[i] != '0;
			end
		end
	end

endmodule

@@ sv/baseline_threshold_charge_integrator_unit.sv @@
`timescale 1ns / 1ps
// Baseline-subtracted threshold charge integrator, four ADC channels.
// Sample channel: sample_ch0..3 plus last_sample, one beat per ADC clock,
// accepted when sample_valid is high and sample_stall low. The first
// window_length beats of a waveform form the per-channel baseline; later
// beats add their excess (sample*W - baseline_sum) to the channel charge
// when it is above excess_threshold*W. Charges saturate at 1069286400.
// Result channel: one beat per waveform, after the last_sample beat, with
// four scaled charges and hit_mask; taken when result_valid is high and
// result_stall low.
// Throughput: one sample beat per cycle, set by the per-lane accumulate
// stage. A taken last beat is registered in stage 1, then sets result_valid.
// While result_stall holds a result, sample beats keep flowing; only a
// second last_sample beat waits in stage 1 until the result is taken.
// Reset clears the waveform state and loads window 30, threshold 20.
// Config writes (cfg_we, cfg_index, cfg_data) must come while idle; not enforced.
module baseline_threshold_charge_integrator_unit import btci_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  sample_t              sample_ch0,
	input  sample_t              sample_ch1,
	input  sample_t              sample_ch2,
	input  sample_t              sample_ch3,
	input  logic                 last_sample,
	output logic                 result_valid,
	input  logic                 result_stall,
	output charge_t              charge_ch0,
	output charge_t              charge_ch1,
	output charge_t              charge_ch2,
	output charge_t              charge_ch3,
	output logic [NUM_LANES-1:0] hit_mask
);

	ctrl_t                   ctrl;
	sample_t [NUM_LANES-1:0] samples;
	charge_t [NUM_LANES-1:0] charge_next;
	charge_t [NUM_LANES-1:0] charge_q;

	assign samples[0] = sample_ch0;
	assign samples[1] = sample_ch1;
	assign samples[2] = sample_ch2;
	assign samples[3] = sample_ch3;

	btci_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.last_sample  (last_sample),
		.out_busy     (result_valid && result_stall),
		.ctrl         (ctrl)
	);

	for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
		btci_lane u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.sample      (samples[i]),
			.charge_next (charge_next[i])
		);
	end

	btci_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire_last    (ctrl.fire && ctrl.last_s1),
		.charge_next  (charge_next),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.charge_q     (charge_q),
		.hit_mask     (hit_mask)
	);

	assign charge_ch0 = charge_q[0];
	assign charge_ch1 = charge_q[1];
	assign charge_ch2 = charge_q[2];
	assign charge_ch3 = charge_q[3];

endmodule

@@ sv/btci_checker.sv @@
`timescale 1ns / 1ps
module btci_checker import btci_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 sample_valid,
	input logic                 sample_stall,
	input logic                 last_sample,
	input logic                 result_valid,
	input logic                 result_stall,
	input charge_t              charge_ch0,
	input charge_t              charge_ch1,
	input charge_t              charge_ch2,
	input charge_t              charge_ch3,
	input logic [NUM_LANES-1:0] hit_mask
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result beat dropped while stalled");

	a_mask: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((charge_ch0 != '0) == hit_mask[0])
			&& ((charge_ch1 != '0) == hit_mask[1])
			&& ((charge_ch2 != '0) == hit_mask[2])
			&& ((charge_ch3 != '0) == hit_mask[3]))
		else $error("hit_mask disagrees with charges");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> charge_ch0 <= CHARGE_MAX && charge_ch1 <= CHARGE_MAX
			&& charge_ch2 <= CHARGE_MAX && charge_ch3 <= CHARGE_MAX)
		else $error("charge above saturation limit");

	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(sample_valid && !sample_stall && last_sample, 2))
		else $error("result without a last sample beat");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !sample_stall)
		else $error("input stalled with empty result register");

endmodule

bind baseline_threshold_charge_integrator_unit btci_checker u_chk (.*);
